>>> hdl/hsr_pkg.sv
// Package for the hot function sample ranker: sizes, codes, state and item types.
// No dependencies; every other file of the block but hsr_ram imports it.
`timescale 1ns / 1ps

package hsr_pkg;

  localparam int unsigned TABLE_DEPTH    = 4096;
  localparam int unsigned TALLY_ENTRIES  = 8;
  localparam int unsigned REPORT_ENTRIES = 5;
  localparam int unsigned QUEUE_DEPTH    = 2;

  localparam int unsigned TBL_AW  = $clog2(TABLE_DEPTH);
  localparam int unsigned CNT_W   = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned TLY_CW  = $clog2(TALLY_ENTRIES + 1);
  localparam int unsigned QPTR_W  = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned MODE_W  = 2;
  localparam int unsigned IDX_W   = 12;
  localparam int unsigned ADDR_W  = 32;
  localparam int unsigned HITS_W  = 16;
  localparam int unsigned RANK_W  = 3;

  localparam logic [HITS_W-1:0] HITS_MAX = '1;

  typedef enum logic [MODE_W-1:0] {
    MODE_LOAD   = 2'd0,
    MODE_SAMPLE = 2'd1,
    MODE_REPORT = 2'd2,
    MODE_NONE   = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    OP_LOAD,
    OP_SAMPLE,
    OP_REPORT
  } op_e;

  typedef enum logic [1:0] {
    SR_IDLE,
    SR_FIRST,
    SR_STEP,
    SR_DONE
  } srch_e;

  typedef enum logic [2:0] {
    B_IDLE,
    B_SAMPLE,
    B_EMPTY,
    B_SORT,
    B_LOOK,
    B_EMIT
  } back_e;

  typedef struct packed {
    op_e               op;
    logic [IDX_W-1:0]  idx;
    logic [ADDR_W-1:0] addr;
  } cmd_t;

  typedef struct packed {
    logic [ADDR_W-1:0] base;
    logic [HITS_W-1:0] hits;
    logic [ADDR_W-1:0] ex;
  } ent_t;

  typedef struct packed {
    logic              start;
    logic [ADDR_W-1:0] addr;
  } srch_req_t;

  typedef struct packed {
    logic              done;
    logic [ADDR_W-1:0] base;
    logic [ADDR_W-1:0] off;
  } srch_rsp_t;

endpackage

>>> hdl/hsr_if.sv
// Valid/ready channel interfaces for the sample ranker input and result items.
// Depends on hsr_pkg for field widths.
`timescale 1ns / 1ps

interface hsr_in_if;
  import hsr_pkg::*;
  logic                valid;
  logic                ready;
  logic [MODE_W-1:0]   mode;
  logic [IDX_W-1:0]    table_index;
  logic [ADDR_W-1:0]   table_addr;
  logic [ADDR_W-1:0]   sample_addr;

  modport source (output valid, mode, table_index, table_addr, sample_addr, input ready);
  modport sink   (input valid, mode, table_index, table_addr, sample_addr, output ready);
endinterface

interface hsr_out_if;
  import hsr_pkg::*;
  logic                valid;
  logic                ready;
  logic [RANK_W-1:0]   rank;
  logic [HITS_W-1:0]   hits;
  logic [ADDR_W-1:0]   func_base;
  logic [ADDR_W-1:0]   offset;
  logic [ADDR_W-1:0]   example_addr;
  logic                empty_window;
  logic                last;

  modport source (output valid, rank, hits, func_base, offset, example_addr, empty_window,
                  last, input ready);
  modport sink   (input valid, rank, hits, func_base, offset, example_addr, empty_window,
                  last, output ready);
endinterface

>>> hdl/hot_function_sample_ranker.sv
// Top level of the hot function sample ranker: front queue, back end, search, table RAM.
// Depends on hsr_pkg, hsr_if, hsr_ram, hsr_front, hsr_search, hsr_back.
//
//   port          dir   handshake      payload
//   in_i          in    valid/ready    mode, table_index, table_addr, sample_addr
//   out_o         out   valid/ready    rank, hits, func_base, offset, example_addr,
//                                      empty_window, last
//   cfg_we_i      in    write enable   cfg_wdata_i = table_count
//
// A load is a single table RAM write in the back end. A sample runs the binary search,
// which makes one table RAM read per cycle. A report runs the compares of the emitted sort
// passes (up to 25), then one search and one output item per ranked entry.
// No clearing pass after reset.
// A two-entry queue lets input items arrive while the back end works; the result register
// holds a result until taken, and the back end waits on it only when it has another one.
`timescale 1ns / 1ps

module hot_function_sample_ranker
  import hsr_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  hsr_in_if.sink           in_i,
  hsr_out_if.source        out_o,
  input  logic             cfg_we_i,
  input  logic [CNT_W-1:0] cfg_wdata_i
);

  logic [CNT_W-1:0]  table_count_q;
  logic [CNT_W-1:0]  count_eff;
  cmd_t              cmd;
  logic              cmd_valid;
  logic              cmd_pop;
  srch_req_t         srch_req;
  srch_rsp_t         srch_rsp;
  logic              tbl_we;
  logic [TBL_AW-1:0] tbl_waddr;
  logic [ADDR_W-1:0] tbl_wdata;
  logic [TBL_AW-1:0] tbl_raddr;
  logic [ADDR_W-1:0] tbl_rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      table_count_q <= '0;
    end else if (cfg_we_i) begin
      table_count_q <= cfg_wdata_i;
    end
  end

  assign count_eff = (table_count_q > CNT_W'(TABLE_DEPTH)) ? CNT_W'(TABLE_DEPTH)
                                                          : table_count_q;

  hsr_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .cmd_o       (cmd),
    .cmd_valid_o (cmd_valid),
    .cmd_pop_i   (cmd_pop)
  );

  hsr_ram #(
    .WIDTH (ADDR_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (tbl_we),
    .waddr_i (tbl_waddr),
    .wdata_i (tbl_wdata),
    .raddr_i (tbl_raddr),
    .rdata_o (tbl_rdata)
  );

  hsr_search u_search (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (srch_req),
    .count_i (count_eff),
    .raddr_o (tbl_raddr),
    .rdata_i (tbl_rdata),
    .rsp_o   (srch_rsp)
  );

  hsr_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .cmd_valid_i (cmd_valid),
    .cmd_pop_o   (cmd_pop),
    .srch_req_o  (srch_req),
    .srch_rsp_i  (srch_rsp),
    .tbl_we_o    (tbl_we),
    .tbl_waddr_o (tbl_waddr),
    .tbl_wdata_o (tbl_wdata),
    .out_o       (out_o)
  );

`ifndef SYNTH
  // an empty report is a single zeroed item
  a_empty_alone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.empty_window |-> out_o.last && out_o.hits == '0 &&
    out_o.rank == '0)
    else $error("empty report item carries data");

  // a ranked function was counted at least once
  a_ranked_hits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.empty_window |-> out_o.hits != '0 && out_o.func_base != '0)
    else $error("ranked item without hits");

  a_rank_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> out_o.rank < RANK_W'(REPORT_ENTRIES))
    else $error("rank beyond report length");
`endif

endmodule

>>> hdl/hsr_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module hsr_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> hdl/hsr_front.sv
// Front end: accepts input items, classifies them and queues commands for the back end.
// Depends on hsr_pkg and hsr_if.
`timescale 1ns / 1ps

module hsr_front
  import hsr_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  hsr_in_if.sink    in_i,
  output cmd_t      cmd_o,
  output logic      cmd_valid_o,
  input  logic      cmd_pop_i
);

  cmd_t              q_mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;
  logic              accept;
  logic              keep;
  cmd_t              cmd_new;

  assign in_i.ready = (cnt_q != QCNT_W'(QUEUE_DEPTH));
  assign accept     = in_i.valid && in_i.ready;

  // Unused modes and idle samples leave no trace, so they never enter the queue.
  always_comb begin
    keep         = 1'b0;
    cmd_new.op   = OP_LOAD;
    cmd_new.idx  = in_i.table_index;
    cmd_new.addr = in_i.table_addr;
    unique case (mode_e'(in_i.mode))
      MODE_LOAD: begin
        keep = 1'b1;
      end
      MODE_SAMPLE: begin
        keep         = (in_i.sample_addr != '0);
        cmd_new.op   = OP_SAMPLE;
        cmd_new.addr = in_i.sample_addr;
      end
      MODE_REPORT: begin
        keep       = 1'b1;
        cmd_new.op = OP_REPORT;
      end
      MODE_NONE: begin
        keep = 1'b0;
      end
    endcase
  end

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (accept && keep) begin
      wr_ptr_d = wr_ptr_q + QPTR_W'(1);
    end
    if (cmd_pop_i) begin
      rd_ptr_d = rd_ptr_q + QPTR_W'(1);
    end
    cnt_d = cnt_q + QCNT_W'(accept && keep) - QCNT_W'(cmd_pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && keep) begin
      q_mem_q[wr_ptr_q] <= cmd_new;
    end
  end

  assign cmd_valid_o = (cnt_q != '0);
  assign cmd_o       = q_mem_q[rd_ptr_q];

endmodule

>>> hdl/hsr_search.sv
// Binary floor search over the function table, one table read per cycle.
// Depends on hsr_pkg; drives the read port of the table RAM.
`timescale 1ns / 1ps

module hsr_search
  import hsr_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  srch_req_t         req_i,
  input  logic [CNT_W-1:0]  count_i,
  output logic [TBL_AW-1:0] raddr_o,
  input  logic [ADDR_W-1:0] rdata_i,
  output srch_rsp_t         rsp_o
);

  srch_e             state_q, state_d;
  logic [ADDR_W-1:0] addr_q, addr_d;
  logic [ADDR_W-1:0] best_q, best_d;
  logic              found_q, found_d;
  logic [CNT_W-1:0]  lo_q, lo_d;
  logic [CNT_W-1:0]  hi_q, hi_d;
  logic [TBL_AW-1:0] mid_q, mid_d;
  logic [CNT_W:0]    sum;
  logic              go;

  always_comb begin
    state_d = state_q;
    addr_d  = addr_q;
    best_d  = best_q;
    found_d = found_q;
    lo_d    = lo_q;
    hi_d    = hi_q;
    mid_d   = mid_q;
    go      = 1'b0;
    raddr_o = '0;
    unique case (state_q)
      SR_IDLE: begin
        if (req_i.start) begin
          addr_d  = req_i.addr;
          found_d = 1'b0;
          if (count_i == '0) begin
            state_d = SR_DONE;
          end else begin
            lo_d    = '0;
            hi_d    = count_i - CNT_W'(1);
            state_d = SR_FIRST;
          end
        end
      end
      SR_FIRST: begin
        // entry 0 is on rdata_i: below it there is no function
        if (addr_q < rdata_i) begin
          state_d = SR_DONE;
        end else begin
          found_d = 1'b1;
          best_d  = rdata_i;
          go      = 1'b1;
        end
      end
      SR_STEP: begin
        if (rdata_i <= addr_q) begin
          best_d = rdata_i;
          lo_d   = CNT_W'(mid_q) + CNT_W'(1);
          go     = (lo_d <= hi_q);
        end else if (mid_q != '0) begin
          hi_d = CNT_W'(mid_q) - CNT_W'(1);
          go   = (lo_q <= hi_d);
        end
        if (!go) begin
          state_d = SR_DONE;
        end
      end
      SR_DONE: begin
        state_d = SR_IDLE;
      end
      default: begin
        state_d = SR_IDLE;
      end
    endcase
    sum = {1'b0, lo_d} + {1'b0, hi_d};
    if (go) begin
      mid_d   = sum[TBL_AW:1];
      raddr_o = mid_d;
      state_d = SR_STEP;
    end else if (state_q == SR_IDLE) begin
      raddr_o = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SR_IDLE;
      found_q <= 1'b0;
    end else begin
      state_q <= state_d;
      found_q <= found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    addr_q <= addr_d;
    best_q <= best_d;
    lo_q   <= lo_d;
    hi_q   <= hi_d;
    mid_q  <= mid_d;
  end

  assign rsp_o.done = (state_q == SR_DONE);
  assign rsp_o.base = found_q ? best_q : '0;
  assign rsp_o.off  = found_q ? (addr_q - best_q) : '0;

endmodule

>>> hdl/hsr_back.sv
// Back end: table loads, tally updates, exchange sort and report output register.
// Depends on hsr_pkg and hsr_if; uses hsr_search through the top level.
`timescale 1ns / 1ps

module hsr_back
  import hsr_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cmd_t              cmd_i,
  input  logic              cmd_valid_i,
  output logic              cmd_pop_o,
  output srch_req_t         srch_req_o,
  input  srch_rsp_t         srch_rsp_i,
  output logic              tbl_we_o,
  output logic [TBL_AW-1:0] tbl_waddr_o,
  output logic [ADDR_W-1:0] tbl_wdata_o,
  hsr_out_if.source         out_o
);

  back_e             state_q, state_d;
  ent_t              slot_q [TALLY_ENTRIES];
  ent_t              slot_d [TALLY_ENTRIES];
  ent_t              shift_v [TALLY_ENTRIES];
  ent_t              cur_q, cur_d;
  ent_t              tail;
  logic [TLY_CW-1:0] used_q, used_d;
  logic [TLY_CW-1:0] len_q, len_d;
  logic [TLY_CW-1:0] steps_q, steps_d;
  logic [RANK_W-1:0] k_q, k_d;
  logic [RANK_W-1:0] n_q, n_d;
  logic [ADDR_W-1:0] off_q, off_d;
  logic [TALLY_ENTRIES-1:0] hit_v;
  logic              out_free;
  logic              clear;

  logic              ov_q, ov_d;
  logic [RANK_W-1:0] o_rank_q, o_rank_d;
  logic [HITS_W-1:0] o_hits_q, o_hits_d;
  logic [ADDR_W-1:0] o_base_q, o_base_d;
  logic [ADDR_W-1:0] o_off_q, o_off_d;
  logic [ADDR_W-1:0] o_ex_q, o_ex_d;
  logic              o_empty_q, o_empty_d;
  logic              o_last_q, o_last_d;

  assign out_free = !ov_q || out_o.ready;

  always_comb begin
    for (int j = 0; j < TALLY_ENTRIES - 1; j++) begin
      shift_v[j] = slot_q[j + 1];
    end
    shift_v[TALLY_ENTRIES - 1] = '0;
    for (int j = 0; j < TALLY_ENTRIES; j++) begin
      hit_v[j] = (TLY_CW'(j) < used_q) && (slot_q[j].base == srch_rsp_i.base);
    end
  end

  always_comb begin
    state_d     = state_q;
    slot_d      = slot_q;
    cur_d       = cur_q;
    used_d      = used_q;
    len_d       = len_q;
    steps_d     = steps_q;
    k_d         = k_q;
    n_d         = n_q;
    off_d       = off_q;
    tail        = slot_q[0];
    clear       = 1'b0;
    cmd_pop_o   = 1'b0;
    srch_req_o  = '0;
    tbl_we_o    = 1'b0;
    tbl_waddr_o = cmd_i.idx[TBL_AW-1:0];
    tbl_wdata_o = cmd_i.addr;
    ov_d        = ov_q && !out_o.ready;
    o_rank_d    = o_rank_q;
    o_hits_d    = o_hits_q;
    o_base_d    = o_base_q;
    o_off_d     = o_off_q;
    o_ex_d      = o_ex_q;
    o_empty_d   = o_empty_q;
    o_last_d    = o_last_q;
    unique case (state_q)
      B_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          unique case (cmd_i.op)
            OP_LOAD: begin
              tbl_we_o = 1'b1;
            end
            OP_SAMPLE: begin
              srch_req_o.start = 1'b1;
              srch_req_o.addr  = cmd_i.addr;
              cur_d.ex         = cmd_i.addr;
              state_d          = B_SAMPLE;
            end
            OP_REPORT: begin
              if (used_q == '0) begin
                state_d = B_EMPTY;
              end else begin
                // pass 0 holds entry 0, the rest circulate through the slots
                cur_d   = slot_q[0];
                slot_d  = shift_v;
                len_d   = used_q - TLY_CW'(1);
                steps_d = used_q - TLY_CW'(1);
                k_d     = '0;
                n_d     = (used_q < TLY_CW'(REPORT_ENTRIES)) ? RANK_W'(used_q)
                                                             : RANK_W'(REPORT_ENTRIES);
                state_d = B_SORT;
              end
            end
            default: begin
            end
          endcase
        end
      end
      B_SAMPLE: begin
        if (srch_rsp_i.done) begin
          state_d = B_IDLE;
          if (srch_rsp_i.base != '0) begin
            if (hit_v != '0) begin
              for (int j = 0; j < TALLY_ENTRIES; j++) begin
                if (hit_v[j] && slot_q[j].hits != HITS_MAX) begin
                  slot_d[j].hits = slot_q[j].hits + HITS_W'(1);
                end
              end
            end else if (used_q < TLY_CW'(TALLY_ENTRIES)) begin
              for (int j = 0; j < TALLY_ENTRIES; j++) begin
                if (TLY_CW'(j) == used_q) begin
                  slot_d[j].base = srch_rsp_i.base;
                  slot_d[j].hits = HITS_W'(1);
                  slot_d[j].ex   = cur_q.ex;
                end
              end
              used_d = used_q + TLY_CW'(1);
            end
          end
        end
      end
      B_EMPTY: begin
        if (out_free) begin
          ov_d      = 1'b1;
          o_rank_d  = '0;
          o_hits_d  = '0;
          o_base_d  = '0;
          o_off_d   = '0;
          o_ex_d    = '0;
          o_empty_d = 1'b1;
          o_last_d  = 1'b1;
          clear     = 1'b1;
          state_d   = B_IDLE;
        end
      end
      B_SORT: begin
        if (steps_q == '0) begin
          srch_req_o.start = 1'b1;
          srch_req_o.addr  = cur_q.ex;
          state_d          = B_LOOK;
        end else begin
          // only a strictly greater count takes the held position
          if (slot_q[0].hits > cur_q.hits) begin
            tail  = cur_q;
            cur_d = slot_q[0];
          end
          for (int j = 0; j < TALLY_ENTRIES; j++) begin
            if (TLY_CW'(j) + TLY_CW'(1) < len_q) begin
              slot_d[j] = shift_v[j];
            end else if (TLY_CW'(j) + TLY_CW'(1) == len_q) begin
              slot_d[j] = tail;
            end
          end
          steps_d = steps_q - TLY_CW'(1);
        end
      end
      B_LOOK: begin
        if (srch_rsp_i.done) begin
          off_d   = srch_rsp_i.off;
          state_d = B_EMIT;
        end
      end
      B_EMIT: begin
        if (out_free) begin
          ov_d      = 1'b1;
          o_rank_d  = k_q;
          o_hits_d  = cur_q.hits;
          o_base_d  = cur_q.base;
          o_off_d   = off_q;
          o_ex_d    = cur_q.ex;
          o_empty_d = 1'b0;
          o_last_d  = (k_q + RANK_W'(1) == n_q);
          if (k_q + RANK_W'(1) == n_q) begin
            clear   = 1'b1;
            state_d = B_IDLE;
          end else begin
            cur_d   = slot_q[0];
            slot_d  = shift_v;
            len_d   = len_q - TLY_CW'(1);
            steps_d = len_q - TLY_CW'(1);
            k_d     = k_q + RANK_W'(1);
            state_d = B_SORT;
          end
        end
      end
      default: begin
        state_d = B_IDLE;
      end
    endcase
    if (clear) begin
      for (int j = 0; j < TALLY_ENTRIES; j++) begin
        slot_d[j] = '0;
      end
      used_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= B_IDLE;
      for (int j = 0; j < TALLY_ENTRIES; j++) begin
        slot_q[j] <= '0;
      end
      used_q  <= '0;
      len_q   <= '0;
      steps_q <= '0;
      k_q     <= '0;
      n_q     <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      slot_q  <= slot_d;
      used_q  <= used_d;
      len_q   <= len_d;
      steps_q <= steps_d;
      k_q     <= k_d;
      n_q     <= n_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q     <= cur_d;
    off_q     <= off_d;
    o_rank_q  <= o_rank_d;
    o_hits_q  <= o_hits_d;
    o_base_q  <= o_base_d;
    o_off_q   <= o_off_d;
    o_ex_q    <= o_ex_d;
    o_empty_q <= o_empty_d;
    o_last_q  <= o_last_d;
  end

  assign out_o.valid        = ov_q;
  assign out_o.rank         = o_rank_q;
  assign out_o.hits         = o_hits_q;
  assign out_o.func_base    = o_base_q;
  assign out_o.offset       = o_off_q;
  assign out_o.example_addr = o_ex_q;
  assign out_o.empty_window = o_empty_q;
  assign out_o.last         = o_last_q;

endmodule
